[rtl/core/fxe_pkg.sv]
// Shared types, constants and CRC helpers of the frame bit encoder.
package fxe_pkg;

  localparam int ID_W   = 11;
  localparam int IND_W  = 5;
  localparam int PLW_W  = 7;
  localparam int CYC_W  = 6;
  localparam int BYTE_W = 8;
  localparam int REQ_W  = 2;

  localparam int HCRC_W = 11;
  localparam int FCRC_W = 24;

  // Longest bit sequence caused by one request (start: TSS, FSS, five bytes).
  localparam int SEQ_W      = 53;
  localparam int CNT_W      = 6;
  localparam int BYTE_SEQ_W = 10;
  localparam int CID_LEN    = 11;

  localparam logic [CNT_W-1:0] BITS_START   = CNT_W'(53);
  localparam logic [CNT_W-1:0] BITS_PAYLOAD = CNT_W'(10);
  localparam logic [CNT_W-1:0] BITS_END     = CNT_W'(42);

  localparam logic [HCRC_W-1:0] HDR_CRC_POLY = 11'h385;
  localparam logic [HCRC_W-1:0] HDR_CRC_INIT = 11'h01A;
  localparam logic [FCRC_W-1:0] FRM_CRC_POLY = 24'h5D6DCB;
  localparam logic [FCRC_W-1:0] SEED_RESET   = 24'hFEDCBA;

  // Only the eight data bits of a byte sequence feed the frame CRC.
  localparam logic [BYTE_SEQ_W-1:0] BYTE_CRC_MASK = 10'b00_1111_1111;

  typedef enum logic [REQ_W-1:0] {
    REQ_START   = 2'd0,
    REQ_PAYLOAD = 2'd1,
    REQ_END     = 2'd2
  } req_t;

  // Load command from the request decoder to the serializer.
  typedef struct packed {
    logic                  valid;
    logic [SEQ_W-1:0]      bits;
    logic [SEQ_W-1:0]      mask;
    logic [CNT_W-1:0]      count;
    logic                  seed_load;
    logic [FCRC_W-1:0]     seed;
  } ld_t;

  // Byte start sequence (high, low) followed by the byte, MSB first.
  function automatic logic [BYTE_SEQ_W-1:0] byte_seq(input logic [BYTE_W-1:0] b);
    return {2'b10, b};
  endfunction

  // Ten steps of the header CRC.
  function automatic logic [HCRC_W-1:0] hdr_crc_half(input logic [HCRC_W-1:0] crc_in,
                                                     input logic [9:0] data);
    logic [HCRC_W-1:0] c;
    logic              fb;
    c = crc_in;
    for (int i = 9; i >= 0; i--) begin
      fb = c[HCRC_W-1] ^ data[i];
      c  = {c[HCRC_W-2:0], 1'b0};
      if (fb) begin
        c = c ^ HDR_CRC_POLY;
      end
    end
    return c;
  endfunction

  // One bit step of the frame CRC.
  function automatic logic [FCRC_W-1:0] frm_crc_bit(input logic [FCRC_W-1:0] crc_in,
                                                    input logic b);
    logic [FCRC_W-1:0] c;
    c = {crc_in[FCRC_W-2:0], 1'b0};
    if (crc_in[FCRC_W-1] ^ b) begin
      c = c ^ FRM_CRC_POLY;
    end
    return c;
  endfunction

endpackage

[rtl/core/fxe_in_if.sv]
// Request channel of the frame bit encoder.
interface fxe_in_if
  import fxe_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [ID_W-1:0]  frame_identifier;
  logic [IND_W-1:0] indicator_bits;
  logic [PLW_W-1:0] payload_words;
  logic [CYC_W-1:0] cycle_number;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output req_type, output frame_identifier,
                  output indicator_bits, output payload_words, output cycle_number,
                  output data_byte, input ready);
  modport sink   (input valid, input req_type, input frame_identifier,
                  input indicator_bits, input payload_words, input cycle_number,
                  input data_byte, output ready);
endinterface

[rtl/core/fxe_out_if.sv]
// Wire bit channel of the frame bit encoder.
interface fxe_out_if;
  logic valid;
  logic ready;
  logic wire_data;
  logic wire_enable_n;
  logic last_bit;

  modport source (output valid, output wire_data, output wire_enable_n,
                  output last_bit, input ready);
  modport sink   (input valid, input wire_data, input wire_enable_n,
                  input last_bit, output ready);
endinterface

[rtl/core/flexray_frame_bit_encoder.sv]
// Top level of the FlexRay frame bit encoder.
//
// The block turns frame requests into wire bits, one bit per output transfer.
// A start request yields 53 bits (two TSS lows, the FSS high and five header
// bytes with the 11-bit header CRC), a payload request yields 10 bits (byte
// start sequence and the byte, MSB first), and an end request yields 42 bits
// (the three bytes of the 24-bit frame CRC, the FES low and 11 CID highs).
// Every byte goes out as high, low, then its eight data bits. Payload and end
// requests outside a frame, and request code three, are dropped without
// output. A start inside a frame abandons the open frame and reloads the CRC
// from cfg_wdata's last written value (reset value 0xFEDCBA, channel A).
// Flow: the output register moves one bit per clock while the receiver is
// ready, and the next request is loaded from the one-entry input register in
// the cycle that the last bit of the previous one leaves the shifter, with no
// gap on the wire side. The frame CRC advances one bit per clock as data bits
// leave the shifter, and stalls with it; the header CRC is computed half at
// input transfer and half at load. An input transfer passes the input register,
// the shifter and the output register before its first bit reaches the wire.
module flexray_frame_bit_encoder
  import fxe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [FCRC_W-1:0]  cfg_wdata,
  fxe_in_if.sink             in_chan,
  fxe_out_if.source          out_chan
);

  // Configured seed of the frame CRC.
  logic [FCRC_W-1:0] seed_r;

  // One-entry input register, so a request can be taken while bits drain.
  logic              st_v_r, st_v_nxt;
  logic [REQ_W-1:0]  st_req_r;
  logic [ID_W-1:0]   st_id_r;
  logic [IND_W-1:0]  st_ind_r;
  logic [PLW_W-1:0]  st_plw_r;
  logic [CYC_W-1:0]  st_cyc_r;
  logic [BYTE_W-1:0] st_data_r;
  logic [HCRC_W-1:0] st_hcrc_r;

  logic              in_frame_r, in_frame_nxt;

  logic              in_fire;
  logic              st_take;
  logic              ser_free;
  logic [FCRC_W-1:0] crc_cur;
  logic [HCRC_W-1:0] hcrc;
  ld_t               ld;

  assign st_take       = st_v_r && ser_free;
  assign in_chan.ready = !st_v_r || st_take;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_comb begin
    st_v_nxt = st_v_r;
    if (in_fire) begin
      st_v_nxt = 1'b1;
    end else if (st_take) begin
      st_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r     <= 1'b0;
      in_frame_r <= 1'b0;
      seed_r     <= SEED_RESET;
    end else begin
      st_v_r     <= st_v_nxt;
      in_frame_r <= in_frame_nxt;
      if (cfg_we) begin
        seed_r <= cfg_wdata;
      end
    end
  end

  // The first half of the header CRC covers the sync and startup bits and the
  // upper eight bits of the frame ID.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      st_req_r  <= in_chan.req_type;
      st_id_r   <= in_chan.frame_identifier;
      st_ind_r  <= in_chan.indicator_bits;
      st_plw_r  <= in_chan.payload_words;
      st_cyc_r  <= in_chan.cycle_number;
      st_data_r <= in_chan.data_byte;
      st_hcrc_r <= hdr_crc_half(HDR_CRC_INIT,
                                {in_chan.indicator_bits[1:0],
                                 in_chan.frame_identifier[ID_W-1:3]});
    end
  end

  // The second half covers the low frame ID bits and the payload length.
  assign hcrc = hdr_crc_half(st_hcrc_r, {st_id_r[2:0], st_plw_r});

  always_comb begin
    ld           = '0;
    ld.seed      = seed_r;
    in_frame_nxt = in_frame_r;
    case (st_req_r)
      REQ_START: begin
        ld.valid     = st_take;
        ld.seed_load = 1'b1;
        ld.count     = BITS_START;
        ld.bits      = {3'b001,
                        byte_seq({st_ind_r, st_id_r[ID_W-1:8]}),
                        byte_seq(st_id_r[7:0]),
                        byte_seq({st_plw_r, hcrc[HCRC_W-1]}),
                        byte_seq(hcrc[9:2]),
                        byte_seq({hcrc[1:0], st_cyc_r})};
        ld.mask      = {3'b000, {5{BYTE_CRC_MASK}}};
        if (st_take) begin
          in_frame_nxt = 1'b1;
        end
      end
      REQ_PAYLOAD: begin
        ld.valid = st_take && in_frame_r;
        ld.count = BITS_PAYLOAD;
        ld.bits  = {byte_seq(st_data_r), {(SEQ_W-BYTE_SEQ_W){1'b0}}};
        ld.mask  = {BYTE_CRC_MASK, {(SEQ_W-BYTE_SEQ_W){1'b0}}};
      end
      REQ_END: begin
        // The trailer uses the CRC including a data bit leaving this cycle.
        ld.valid = st_take && in_frame_r;
        ld.count = BITS_END;
        ld.bits  = {byte_seq(crc_cur[23:16]),
                    byte_seq(crc_cur[15:8]),
                    byte_seq(crc_cur[7:0]),
                    1'b0,
                    {CID_LEN{1'b1}},
                    {(SEQ_W-3*BYTE_SEQ_W-1-CID_LEN){1'b0}}};
        ld.mask  = '0;
        if (st_take) begin
          in_frame_nxt = 1'b0;
        end
      end
      default: begin
        ld.valid = 1'b0;
      end
    endcase
  end

  fxe_serializer u_ser (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld       (ld),
    .free     (ser_free),
    .crc_cur  (crc_cur),
    .out_chan (out_chan)
  );

endmodule

[rtl/core/fxe_serializer.sv]
// Bit serializer with output register and bit-serial frame CRC.
module fxe_serializer
  import fxe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  ld_t                ld,
  output logic               free,
  output logic [FCRC_W-1:0]  crc_cur,
  fxe_out_if.source          out_chan
);

  logic [SEQ_W-1:0]  sh_r,   sh_nxt;
  logic [SEQ_W-1:0]  mask_r, mask_nxt;
  logic [CNT_W-1:0]  cnt_r,  cnt_nxt;
  logic [FCRC_W-1:0] crc_r,  crc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_data_r,  out_data_nxt;
  logic              out_last_r,  out_last_nxt;
  logic              move;

  assign move = (cnt_r != '0) && (!out_valid_r || out_chan.ready);

  // A bit that leaves the shifter this cycle updates the CRC right away, so a
  // trailer loaded in the same cycle sees the complete frame CRC.
  assign crc_cur = (move && mask_r[SEQ_W-1]) ? frm_crc_bit(crc_r, sh_r[SEQ_W-1]) : crc_r;
  assign free    = (cnt_r == '0) || (move && (cnt_r == CNT_W'(1)));

  always_comb begin
    sh_nxt   = sh_r;
    mask_nxt = mask_r;
    cnt_nxt  = cnt_r;
    if (ld.valid) begin
      sh_nxt   = ld.bits;
      mask_nxt = ld.mask;
      cnt_nxt  = ld.count;
    end else if (move) begin
      sh_nxt   = {sh_r[SEQ_W-2:0], 1'b0};
      mask_nxt = {mask_r[SEQ_W-2:0], 1'b0};
      cnt_nxt  = cnt_r - CNT_W'(1);
    end
    crc_nxt = (ld.valid && ld.seed_load) ? ld.seed : crc_cur;
  end

  always_comb begin
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r;
    if (move) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = sh_r[SEQ_W-1];
      out_last_nxt  = (cnt_r == CNT_W'(1));
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      crc_r       <= SEED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r       <= sh_nxt;
    mask_r     <= mask_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.wire_data     = out_data_r;
  assign out_chan.wire_enable_n = 1'b0;
  assign out_chan.last_bit      = out_last_r;

endmodule

[bench/testbench.sv]
// Self-checking testbench for the FlexRay frame bit encoder: frame requests in, wire bits out.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fxe_pkg::*;

  // The request code that the package leaves unnamed. The block must drop it.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // Cycles allowed after the last expected bit before the block counts as idle.
  localparam int IDLE_SETTLE     = 8;
  localparam int END_SETTLE      = 20;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 70;

  // How the bits of a request are checked. Most requests go through the
  // predictor. Directed rows whose outcome is obvious carry it in the table:
  // a dropped request yields no bits, and a payload byte inside a frame yields
  // the byte start sequence and the byte itself.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_SILENT,
    CHK_BYTE
  } check_mode_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [ID_W-1:0]   id;
    logic [IND_W-1:0]  ind;
    logic [PLW_W-1:0]  plw;
    logic [CYC_W-1:0]  cyc;
    logic [BYTE_W-1:0] data;
    check_mode_t       chk;
  } frame_req_t;

  typedef struct packed {
    logic data;
    logic enable_n;
    logic last;
  } wire_bit_t;

  // Directed stimulus. Columns: request, frame ID, indicators, payload words,
  // cycle number, data byte, how the resulting bits are checked.
  localparam frame_req_t DIRECTED [22] = '{
    // Nothing is open after reset, so payload, end and the unused code are dropped.
    '{REQ_PAYLOAD, 11'h000, 5'h00, 7'h00, 6'h00, 8'hA5, CHK_SILENT},
    '{REQ_END,     11'h000, 5'h00, 7'h00, 6'h00, 8'h00, CHK_SILENT},
    '{REQ_UNUSED,  11'h7FF, 5'h1F, 7'h7F, 6'h3F, 8'hFF, CHK_SILENT},
    // An all-zero header with the smallest and largest payload bytes.
    '{REQ_START,   11'h000, 5'h00, 7'h00, 6'h00, 8'h00, CHK_MODEL},
    '{REQ_PAYLOAD, 11'h000, 5'h00, 7'h00, 6'h00, 8'h00, CHK_BYTE},
    '{REQ_PAYLOAD, 11'h7FF, 5'h1F, 7'h7F, 6'h3F, 8'hFF, CHK_BYTE},
    '{REQ_END,     11'h000, 5'h00, 7'h00, 6'h00, 8'h00, CHK_MODEL},
    // An all-ones header, then single-bit payload bytes.
    '{REQ_START,   11'h7FF, 5'h1F, 7'h7F, 6'h3F, 8'h00, CHK_MODEL},
    '{REQ_PAYLOAD, 11'h000, 5'h00, 7'h00, 6'h00, 8'h80, CHK_BYTE},
    '{REQ_PAYLOAD, 11'h000, 5'h00, 7'h00, 6'h00, 8'h01, CHK_BYTE},
    // A start inside an open frame abandons it and reloads the CRC seed.
    '{REQ_START,   11'h555, 5'h0A, 7'h2A, 6'h15, 8'h3C, CHK_MODEL},
    '{REQ_PAYLOAD, 11'h000, 5'h00, 7'h00, 6'h00, 8'h5A, CHK_BYTE},
    // The unused code is dropped inside a frame too.
    '{REQ_UNUSED,  11'h2AA, 5'h15, 7'h55, 6'h2A, 8'hC3, CHK_SILENT},
    '{REQ_END,     11'h000, 5'h00, 7'h00, 6'h00, 8'h00, CHK_MODEL},
    // The frame is closed now, so a second end and a payload are dropped.
    '{REQ_END,     11'h7FF, 5'h1F, 7'h7F, 6'h3F, 8'hFF, CHK_SILENT},
    '{REQ_PAYLOAD, 11'h000, 5'h00, 7'h00, 6'h00, 8'hC3, CHK_SILENT},
    // A frame with no payload at all.
    '{REQ_START,   11'h2AA, 5'h15, 7'h55, 6'h2A, 8'h00, CHK_MODEL},
    '{REQ_END,     11'h000, 5'h00, 7'h00, 6'h00, 8'h00, CHK_MODEL},
    // Sync and startup indicators set, which feed the header CRC.
    '{REQ_START,   11'h001, 5'h03, 7'h01, 6'h01, 8'h00, CHK_MODEL},
    '{REQ_PAYLOAD, 11'h000, 5'h00, 7'h00, 6'h00, 8'hAA, CHK_BYTE},
    '{REQ_PAYLOAD, 11'h000, 5'h00, 7'h00, 6'h00, 8'h55, CHK_BYTE},
    '{REQ_END,     11'h000, 5'h00, 7'h00, 6'h00, 8'h00, CHK_MODEL}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [FCRC_W-1:0] cfg_wdata = '0;

  fxe_in_if  in_chan ();
  fxe_out_if out_chan ();

  flexray_frame_bit_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  // Shadow of the block's state: the seed register, the running frame CRC and
  // whether a frame is open. Values match the block right after reset.
  logic [FCRC_W-1:0] seed_shadow = SEED_RESET;
  logic [FCRC_W-1:0] frame_crc_shadow = SEED_RESET;
  logic              frame_open = 1'b0;

  // Bits that the next request produces, and all wire bits still awaited.
  wire_bit_t fresh_bits[$];
  wire_bit_t bits_due[$];

  // Check mode of the request currently offered on the input channel.
  check_mode_t active_check = CHK_MODEL;

  int fail_count = 0;
  int bits_checked = 0;
  int starts_seen = 0;
  int payloads_seen = 0;
  int ends_seen = 0;
  int dropped_seen = 0;
  int result_items = 0;

  // Idling knobs, in percent, and the receiver's long hold-off in cycles.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Header CRC over the sync bit, the startup bit, the frame ID and the payload
  // length, 20 bits MSB first.
  function automatic logic [HCRC_W-1:0] header_check(input logic [IND_W-1:0] ind,
                                                     input logic [ID_W-1:0] id,
                                                     input logic [PLW_W-1:0] plw);
    logic [19:0]       covered;
    logic [HCRC_W-1:0] crc;
    logic              fb;
    covered = {ind[1:0], id, plw};
    crc = HDR_CRC_INIT;
    for (int i = 19; i >= 0; i--) begin
      fb = crc[HCRC_W-1] ^ covered[i];
      crc = {crc[HCRC_W-2:0], 1'b0};
      if (fb) begin
        crc = crc ^ HDR_CRC_POLY;
      end
    end
    return crc;
  endfunction

  function automatic void emit_bit(input logic b);
    fresh_bits.push_back('{b, 1'b0, 1'b0});
  endfunction

  // A byte goes out as high, low and then its eight bits, MSB first. Header and
  // payload bytes also feed the frame CRC; the CRC bytes themselves do not.
  function automatic void emit_byte(input logic [BYTE_W-1:0] b, input logic fold);
    logic fb;
    emit_bit(1'b1);
    emit_bit(1'b0);
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      emit_bit(b[i]);
    end
    if (fold) begin
      for (int i = BYTE_W - 1; i >= 0; i--) begin
        fb = frame_crc_shadow[FCRC_W-1] ^ b[i];
        frame_crc_shadow = {frame_crc_shadow[FCRC_W-2:0], 1'b0};
        if (fb) begin
          frame_crc_shadow = frame_crc_shadow ^ FRM_CRC_POLY;
        end
      end
    end
  endfunction

  // Works out the wire bits of one request and advances the shadow state.
  function automatic void encode_request(input frame_req_t r);
    logic [HCRC_W-1:0] hcrc;
    logic [FCRC_W-1:0] crc_out;
    fresh_bits.delete();
    case (r.req)
      REQ_START: begin
        hcrc = header_check(r.ind, r.id, r.plw);
        frame_crc_shadow = seed_shadow;
        frame_open = 1'b1;
        // Transmission start sequence (two lows) and frame start sequence.
        emit_bit(1'b0);
        emit_bit(1'b0);
        emit_bit(1'b1);
        emit_byte({r.ind, r.id[ID_W-1:8]}, 1'b1);
        emit_byte(r.id[7:0], 1'b1);
        emit_byte({r.plw, hcrc[HCRC_W-1]}, 1'b1);
        emit_byte(hcrc[HCRC_W-2:2], 1'b1);
        emit_byte({hcrc[1:0], r.cyc}, 1'b1);
      end
      REQ_PAYLOAD: begin
        if (frame_open) begin
          emit_byte(r.data, 1'b1);
        end
      end
      REQ_END: begin
        if (frame_open) begin
          crc_out = frame_crc_shadow;
          emit_byte(crc_out[23:16], 1'b0);
          emit_byte(crc_out[15:8], 1'b0);
          emit_byte(crc_out[7:0], 1'b0);
          // Frame end sequence, then the channel idle delimiter.
          emit_bit(1'b0);
          repeat (CID_LEN) emit_bit(1'b1);
          frame_open = 1'b0;
        end
      end
      default: ;
    endcase
    if (fresh_bits.size() > 0) begin
      fresh_bits[fresh_bits.size()-1].last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor and scoreboard. Everything here samples at the rising edge, before
  // the block's own registers update, while the bench drives on falling edges.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    frame_req_t           taken;
    wire_bit_t            want;
    logic [BYTE_SEQ_W-1:0] seq;
    if (cfg_we) begin
      seed_shadow = cfg_wdata;
    end
    if (in_chan.valid && in_chan.ready) begin
      taken = '{in_chan.req_type, in_chan.frame_identifier, in_chan.indicator_bits,
                in_chan.payload_words, in_chan.cycle_number, in_chan.data_byte,
                active_check};
      encode_request(taken);
      // The shadow state always advances; typed rows only replace the bits.
      case (taken.chk)
        CHK_SILENT: ;
        CHK_BYTE: begin
          seq = {2'b10, taken.data};
          for (int i = BYTE_SEQ_W - 1; i >= 0; i--) begin
            bits_due.push_back('{seq[i], 1'b0, i == 0});
          end
        end
        default: begin
          foreach (fresh_bits[i]) bits_due.push_back(fresh_bits[i]);
        end
      endcase
      if (fresh_bits.size() == 0) begin
        dropped_seen++;
      end else begin
        result_items++;
        case (taken.req)
          REQ_START:   starts_seen++;
          REQ_PAYLOAD: payloads_seen++;
          default:     ends_seen++;
        endcase
      end
    end
    if (out_chan.valid && out_chan.ready) begin
      if (bits_due.size() == 0) begin
        $error("wire bit transfer with no bit expected: wire_data %0b", out_chan.wire_data);
        fail_count++;
      end else begin
        want = bits_due.pop_front();
        bits_checked++;
        if (out_chan.wire_data !== want.data) begin
          $error("wire_data mismatch: expected %0b, actual %0b", want.data,
                 out_chan.wire_data);
          fail_count++;
        end
        if (out_chan.wire_enable_n !== want.enable_n) begin
          $error("wire_enable_n mismatch: expected %0b, actual %0b", want.enable_n,
                 out_chan.wire_enable_n);
          fail_count++;
        end
        if (out_chan.last_bit !== want.last) begin
          $error("last_bit mismatch: expected %0b, actual %0b", want.last,
                 out_chan.last_bit);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. Ready changes on falling edges. A long hold-off, when requested,
  // takes precedence over random stalls so the block backs up into its input.
  // ---------------------------------------------------------------------------
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_chan.ready = 1'b0;
        hold_left--;
      end else begin
        out_chan.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offers one request and returns on the falling edge after its transfer.
  // Valid stays high on return so back-to-back requests leave no gap; whoever
  // does not follow up at once with another request must lower it.
  task automatic offer(input frame_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid            = 1'b1;
    in_chan.req_type         = r.req;
    in_chan.frame_identifier = r.id;
    in_chan.indicator_bits   = r.ind;
    in_chan.payload_words    = r.plw;
    in_chan.cycle_number     = r.cyc;
    in_chan.data_byte        = r.data;
    active_check             = r.chk;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  // Stops offering, waits for every awaited bit, then lets the block settle.
  task automatic drain(input int settle);
    in_chan.valid = 1'b0;
    while (bits_due.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_seed(input logic [FCRC_W-1:0] value);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Every field random over its full range; callers pick the request code.
  function automatic frame_req_t random_req(input logic [REQ_W-1:0] req);
    frame_req_t r;
    r.req  = req;
    r.id   = ID_W'($urandom_range(2047));
    r.ind  = IND_W'($urandom_range(31));
    r.plw  = PLW_W'($urandom_range(127));
    r.cyc  = CYC_W'($urandom_range(63));
    r.data = BYTE_W'($urandom_range(255));
    r.chk  = CHK_MODEL;
    return r;
  endfunction

  // One well-formed frame with random content, sprinkled with noise: dropped
  // requests before the start, the unused code inside, and now and then a
  // restart that abandons the frame. Most frames are short; a few are long.
  task automatic random_frame(input bit pause_mid, input bit hold_receiver);
    int n_bytes;
    n_bytes = ($urandom_range(99) < 85) ? $urandom_range(8) : $urandom_range(40, 9);
    if (hold_receiver) begin
      n_bytes = 24;
    end
    if (pause_mid && n_bytes < 2) begin
      n_bytes = 2;
    end
    if ($urandom_range(99) < 15) begin
      // No frame is open here, so payload, end and the unused code are all dropped.
      offer(random_req(REQ_W'($urandom_range(3, 1))));
    end
    if (hold_receiver) begin
      hold_left = HOLD_OFF_CYCLES;
    end
    offer(random_req(REQ_START));
    for (int k = 0; k < n_bytes; k++) begin
      if ($urandom_range(99) < 3) begin
        offer(random_req(REQ_UNUSED));
      end
      if ($urandom_range(99) < 2) begin
        offer(random_req(REQ_START));
      end
      if (pause_mid && k == n_bytes / 2) begin
        // The sender goes quiet mid-frame until the wire has caught up.
        drain(0);
      end
      offer(random_req(REQ_PAYLOAD));
    end
    offer(random_req(REQ_END));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int                target;
    int                frame_no;
    logic [FCRC_W-1:0] seed;
    in_chan.valid            = 1'b0;
    in_chan.req_type         = REQ_START;
    in_chan.frame_identifier = '0;
    in_chan.indicator_bits   = '0;
    in_chan.payload_words    = '0;
    in_chan.cycle_number     = '0;
    in_chan.data_byte        = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, at the reset seed (channel A).
    foreach (DIRECTED[k]) offer(DIRECTED[k]);

    // Random phases. Each one starts from an idle block, loads a new seed and
    // runs with its own idling pattern.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain(IDLE_SETTLE);
      case (p)
        0:       seed = 24'hABCDEF;
        1:       seed = 24'h000000;
        2:       seed = 24'hFFFFFF;
        4:       seed = SEED_RESET;
        default: seed = FCRC_W'($urandom);
      endcase
      write_seed(seed);
      case (p)
        1: begin
          send_idle_pct = 53;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 53;
        end
        3, 5: begin
          send_idle_pct = 15;
          recv_stall_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      target = result_items + ITEMS_PER_PHASE;
      frame_no = 0;
      while (result_items < target) begin
        // The receiver's long hold-off lands in a phase with no other idling.
        random_frame(frame_no == 2, p == 4 && frame_no == 1);
        frame_no++;
      end
    end

    drain(END_SETTLE);
    $display("Covered %0d start, %0d payload and %0d end transfers plus %0d dropped requests;",
             starts_seen, payloads_seen, ends_seen, dropped_seen);
    $display("%0d wire bits checked over %0d idling phases and six CRC seeds.",
             bits_checked, NUM_PHASES);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
